[src/vfdc_pkg.sv]
// Package with shared types, constants and codes of the frame descriptor cache.
package vfdc_pkg;

  localparam int unsigned DefRingDepth = 256;
  localparam int unsigned DefChannels  = 2;
  localparam int unsigned DefSeqBits   = 48;

  localparam int unsigned LenW   = 24;
  localparam int unsigned TypeW  = 2;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned QSeqW  = 48;
  localparam int unsigned TotalW = 25;
  localparam int unsigned DescW  = LenW + TypeW;

  localparam logic [TotalW-1:0] BudgetReset = TotalW'(2 * 1024 * 1024);

  typedef enum logic [1:0] {
    OpAdd     = 2'd0,
    OpGet     = 2'd1,
    OpPrevKey = 2'd2,
    OpLastKey = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StMiss    = 2'd1,
    StBadType = 2'd2,
    StDropped = 2'd3
  } status_e;

  localparam logic [TypeW-1:0] TypeKey = 2'd1;
  localparam logic [TypeW-1:0] TypeMax = 2'd2;

  localparam logic [0:0] RegBudget = 1'b0;

  typedef enum logic [2:0] {
    SIdle,
    SDecide,
    SEvictRd,
    SEvictWait,
    SEvictUpd,
    SScanRd,
    SScanWait,
    SOut
  } state_e;

endpackage

[src/vfdc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module vfdc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[src/video_frame_descriptor_cache_top.sv]
// Top level of the video frame descriptor cache: sequencer, channel state and stores.
//
// Usage: one word enters on the input channel (op, channel, frame fields,
// seq_query) when in_valid_i is high and in_stall_o is low. Exactly one
// result word leaves on the output channel for each input word, held until
// out_stall_i is low while out_valid_o is high.
// Sequence: an add without eviction goes from acceptance to a decision and
// then shows its result. Each evicted descriptor adds a store read, a read
// wait, an update and a new decision. A get reads the store once after the
// decision. A key-frame scan reads one descriptor at a time, newest first,
// until it finds a key frame or reaches the oldest held one. The descriptor
// store has a single read port.
// Throughput: one word at a time; in_stall_o is high from acceptance until
// the cycle after the result word has been taken, so no new word is taken
// while one is in flight.
// Reset: all channels are unstarted and empty, byte_budget is 2097152.
// The descriptor store is not cleared and needs no clearing pass.
// A stalled receiver holds the result in the output register and the block
// stays busy until it is taken. byte_budget is written over the APB port at
// byte address 0; the user must write it only while the block is idle (not enforced).
module video_frame_descriptor_cache_top #(
  parameter int unsigned RING_DEPTH = vfdc_pkg::DefRingDepth,
  parameter int unsigned CHANNELS   = vfdc_pkg::DefChannels,
  parameter int unsigned SEQ_BITS   = vfdc_pkg::DefSeqBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               op_i,
  input  logic                     channel_i,
  input  logic [vfdc_pkg::LenW-1:0]  frame_len_i,
  input  logic [vfdc_pkg::TypeW-1:0] frame_type_i,
  input  logic [vfdc_pkg::TimeW-1:0] timestamp_i,
  input  logic [vfdc_pkg::QSeqW-1:0] seq_query_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [vfdc_pkg::QSeqW-1:0] seq_out_o,
  output logic [vfdc_pkg::LenW-1:0]  len_out_o,
  output logic [vfdc_pkg::TypeW-1:0] type_out_o,
  output logic [vfdc_pkg::TimeW-1:0] time_out_o
);

  import vfdc_pkg::*;

  localparam int unsigned SlotW = $clog2(RING_DEPTH);
  localparam int unsigned CntW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MemD  = CHANNELS * (2 ** SlotW);
  localparam int unsigned AddrW = $clog2(MemD);
  localparam logic [SEQ_BITS-1:0] SeqOne = SEQ_BITS'(1);
  localparam logic [CntW-1:0]     CntFull = CntW'(RING_DEPTH);
  localparam logic [SlotW:0]      RingSpan = (SlotW+1)'(RING_DEPTH);
  localparam logic [SlotW-1:0]    SlotLast = SlotW'(RING_DEPTH - 1);

  // Per-channel state.
  logic [CHANNELS-1:0]     started_q, started_d;
  logic [SEQ_BITS-1:0]     next_seq_q [CHANNELS];
  logic [SEQ_BITS-1:0]     oldest_seq_q [CHANNELS];
  logic [TotalW-1:0]       total_q [CHANNELS];
  logic [CntW-1:0]         count_q [CHANNELS];
  logic [SlotW-1:0]        oslot_q [CHANNELS];

  logic [TotalW-1:0] budget_q;

  // Latched item.
  op_e               op_q;
  logic [ChW-1:0]    ch_q;
  logic [LenW-1:0]   len_q;
  logic [TypeW-1:0]  typ_q;
  logic [TimeW-1:0]  ts_q;
  logic [SEQ_BITS-1:0] qry_q;
  logic              ch_ok_q;

  // Scan position and result registers.
  logic [CntW-1:0]   pos_q, pos_d;
  state_e            state_q, state_d;
  logic [1:0]        st_q;
  logic [QSeqW-1:0]  seq_q;
  logic [LenW-1:0]   olen_q;
  logic [TypeW-1:0]  otyp_q;
  logic [TimeW-1:0]  otim_q;

  logic              accept;
  logic              cfg_wr;

  // Memory ports.
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [DescW-1:0]  rd_desc;
  logic [TimeW-1:0]  rd_time;

  // Current channel views.
  logic [SEQ_BITS-1:0] c_oseq, c_nseq, q_off;
  logic [TotalW-1:0]   c_tot;
  logic [CntW-1:0]     c_cnt;
  logic [SlotW-1:0]    c_oslot, rd_slot, wr_slot;
  logic [SlotW:0]      rd_sum, wr_sum;
  logic                c_started;
  logic                q_held;
  logic [TotalW:0]     tot_sum;

  assign accept = in_valid_i && !in_stall_o;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? 32'(budget_q) : 32'd0;

  assign c_oseq    = oldest_seq_q[ch_q];
  assign c_nseq    = next_seq_q[ch_q];
  assign c_tot     = total_q[ch_q];
  assign c_cnt     = count_q[ch_q];
  assign c_oslot   = oslot_q[ch_q];
  assign c_started = started_q[ch_q];
  assign q_off     = qry_q - c_oseq;
  assign q_held    = q_off < SEQ_BITS'(c_cnt);
  assign tot_sum   = {1'b0, c_tot} + (TotalW+1)'(len_q);

  // Store addresses of ring position pos_q and of the append slot, wrapping at the ring depth.
  assign rd_sum    = (SlotW+1)'(c_oslot) + (SlotW+1)'(pos_q);
  assign wr_sum    = (SlotW+1)'(c_oslot) + (SlotW+1)'(c_cnt);
  assign rd_slot   = (rd_sum >= RingSpan) ? SlotW'(rd_sum - RingSpan) : SlotW'(rd_sum);
  assign wr_slot   = (wr_sum >= RingSpan) ? SlotW'(wr_sum - RingSpan) : SlotW'(wr_sum);
  assign mem_raddr = AddrW'({ch_q, rd_slot});
  assign mem_waddr = AddrW'({ch_q, wr_slot});

  vfdc_ram #(.Width(DescW), .Depth(MemD)) u_desc (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i({len_q, typ_q}),
    .raddr_i(mem_raddr), .rdata_o(rd_desc)
  );
  vfdc_ram #(.Width(TimeW), .Depth(MemD)) u_time (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(ts_q),
    .raddr_i(mem_raddr), .rdata_o(rd_time)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:      if (accept) state_d = SDecide;
      SDecide: begin
        if (!ch_ok_q) begin
          state_d = SOut;
        end else if (op_q == OpAdd) begin
          if (typ_q > TypeMax || (!c_started && typ_q != TypeKey)) begin
            state_d = SOut;
          end else if (c_cnt != '0 && (c_tot >= budget_q || c_cnt >= CntFull)) begin
            state_d = SEvictRd;
          end else begin
            state_d = SOut;
          end
        end else if (!c_started) begin
          state_d = SOut;
        end else if (op_q == OpGet) begin
          state_d = q_held ? SScanRd : SOut;
        end else if (op_q == OpPrevKey) begin
          state_d = (q_held && q_off != '0) ? SScanRd : SOut;
        end else begin
          state_d = (c_cnt != '0) ? SScanRd : SOut;
        end
      end
      SEvictRd:   state_d = SEvictWait;
      SEvictWait: state_d = SEvictUpd;
      SEvictUpd:  state_d = SDecide;
      SScanRd:    state_d = SScanWait;
      SScanWait: begin
        if (op_q == OpGet || rd_desc[TypeW-1:0] == TypeKey || pos_q == '0) begin
          state_d = SOut;
        end else begin
          state_d = SScanRd;
        end
      end
      SOut:       if (!out_stall_i) state_d = SIdle;
      default:    state_d = SIdle;
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    mem_we    = 1'b0;
    started_d = started_q;
    pos_d     = pos_q;
    if (state_q == SDecide && ch_ok_q && op_q == OpAdd && typ_q <= TypeMax &&
        (c_started || typ_q == TypeKey) &&
        !(c_cnt != '0 && (c_tot >= budget_q || c_cnt >= CntFull))) begin
      mem_we = 1'b1;
      started_d[ch_q] = 1'b1;
    end
    if (state_q == SDecide) begin
      case (op_q)
        OpAdd:     pos_d = '0;
        OpGet:     pos_d = CntW'(q_off);
        OpPrevKey: pos_d = CntW'(q_off) - CntW'(1);
        OpLastKey: pos_d = c_cnt - CntW'(1);
        default:   pos_d = '0;
      endcase
    end else if (state_q == SScanWait && pos_q != '0) begin
      pos_d = pos_q - CntW'(1);
    end
  end

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);
  assign status_o    = st_q;
  assign seq_out_o   = seq_q;
  assign len_out_o   = olen_q;
  assign type_out_o  = otyp_q;
  assign time_out_o  = otim_q;

  // Control and channel registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      started_q <= '0;
      budget_q  <= BudgetReset;
      pos_q     <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        next_seq_q[c]   <= '0;
        oldest_seq_q[c] <= '0;
        total_q[c]      <= '0;
        count_q[c]      <= '0;
        oslot_q[c]      <= '0;
      end
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      pos_q     <= pos_d;
      if (cfg_wr && paddr == {RegBudget, 1'b0}) begin
        budget_q <= pwdata[TotalW-1:0];
      end
      if (mem_we) begin
        next_seq_q[ch_q] <= c_nseq + SeqOne;
        count_q[ch_q]    <= c_cnt + CntW'(1);
        total_q[ch_q]    <= tot_sum[TotalW] ? '1 : tot_sum[TotalW-1:0];
      end
      if (state_q == SEvictUpd) begin
        count_q[ch_q]      <= c_cnt - CntW'(1);
        oslot_q[ch_q]      <= (c_oslot == SlotLast) ? '0 : c_oslot + SlotW'(1);
        oldest_seq_q[ch_q] <= c_oseq + SeqOne;
        if (c_cnt == CntW'(1) || c_tot < TotalW'(rd_desc[DescW-1:TypeW])) begin
          total_q[ch_q] <= '0;
        end else begin
          total_q[ch_q] <= c_tot - TotalW'(rd_desc[DescW-1:TypeW]);
        end
      end
    end
  end

  // Item and result registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(op_i);
      ch_q    <= ChW'(channel_i);
      ch_ok_q <= ({{(32-1){1'b0}}, channel_i} < 32'(CHANNELS));
      len_q   <= frame_len_i;
      typ_q   <= frame_type_i;
      ts_q    <= timestamp_i;
      qry_q   <= SEQ_BITS'(seq_query_i);
      st_q    <= StMiss;
      seq_q   <= '0;
      olen_q  <= '0;
      otyp_q  <= '0;
      otim_q  <= '0;
    end
    if (state_q == SDecide && ch_ok_q && op_q == OpAdd) begin
      if (typ_q > TypeMax) begin
        st_q <= StBadType;
      end else if (!c_started && typ_q != TypeKey) begin
        st_q <= StDropped;
      end else if (mem_we) begin
        st_q  <= StOk;
        seq_q <= QSeqW'(c_nseq);
      end
    end
    if (state_q == SScanWait) begin
      if (op_q == OpGet) begin
        st_q   <= StOk;
        seq_q  <= QSeqW'(qry_q);
        olen_q <= rd_desc[DescW-1:TypeW];
        otyp_q <= rd_desc[TypeW-1:0];
        otim_q <= rd_time;
      end else if (rd_desc[TypeW-1:0] == TypeKey) begin
        st_q  <= StOk;
        seq_q <= QSeqW'(c_oseq + SEQ_BITS'(pos_q));
      end
    end
  end

  // Checks on the sequencer.
  property p_busy_stall;
    @(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o;
  endproperty
  a_busy_stall: assert property (p_busy_stall) else $error("result shown while idle");

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(seq_out_o);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("stalled result changed");

  for (genvar gc = 0; gc < CHANNELS; gc++) begin : g_count_chk
    a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      count_q[gc] <= CntFull) else $error("ring count overflow");
  end

  property p_accept_decide;
    @(posedge clk_i) disable iff (!rst_ni) accept |=> state_q == SDecide;
  endproperty
  a_accept_decide: assert property (p_accept_decide) else $error("accept did not start");

endmodule

[tb/sv/video_frame_descriptor_cache_top_tb.sv]
// Self-checking testbench for the video frame descriptor cache top level.
`timescale 1ns / 1ps
module video_frame_descriptor_cache_top_tb;
  import vfdc_pkg::*;

  localparam int unsigned RingDepth  = DefRingDepth;
  localparam int unsigned CycleLimit = 40000000;
  localparam int unsigned ShownErrs  = 40;

  typedef struct packed {
    status_e             st;
    logic [QSeqW-1:0]    seq;
    logic [LenW-1:0]     len;
    logic [TypeW-1:0]    typ;
    logic [TimeW-1:0]    tm;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] op_i = '0;
  logic channel_i = 1'b0;
  logic [LenW-1:0] frame_len_i = '0;
  logic [TypeW-1:0] frame_type_i = '0;
  logic [TimeW-1:0] timestamp_i = '0;
  logic [QSeqW-1:0] seq_query_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [QSeqW-1:0] seq_out_o;
  logic [LenW-1:0] len_out_o;
  logic [TypeW-1:0] type_out_o;
  logic [TimeW-1:0] time_out_o;

  video_frame_descriptor_cache_top u_dut (.*);

  always #10 clk_i = ~clk_i;

  // Shadow copy of the cache state, updated as words are sent.
  logic [TotalW-1:0] budget_q;
  logic              ch_started [2];
  logic [QSeqW-1:0]  ch_next_seq [2];
  logic [QSeqW-1:0]  ch_oldest_seq [2];
  logic [TotalW-1:0] ch_total [2];
  int unsigned       ch_count [2];
  int unsigned       ch_oldest_slot [2];
  logic [LenW-1:0]   ring_len [2][RingDepth];
  logic [TypeW-1:0]  ring_type [2][RingDepth];
  logic [TimeW-1:0]  ring_time [2][RingDepth];

  frame_result_t pending_results[$];
  int unsigned   err_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   hold_cycles = 0;
  int unsigned   hold_count = 0;

  function automatic int unsigned slot_at(int unsigned ch, int unsigned pos);
    return (ch_oldest_slot[ch] + pos) % RingDepth;
  endfunction

  function automatic void drop_oldest(int unsigned ch);
    int unsigned s;
    s = slot_at(ch, 0);
    ch_total[ch] = (ch_total[ch] >= ring_len[ch][s]) ? ch_total[ch] - ring_len[ch][s] : '0;
    ch_count[ch]--;
    ch_oldest_slot[ch] = (ch_oldest_slot[ch] + 1) % RingDepth;
    ch_oldest_seq[ch] = ch_oldest_seq[ch] + 1'b1;
    if (ch_count[ch] == 0) ch_total[ch] = '0;
  endfunction

  // Newest key frame below position limit, or -1.
  function automatic int newest_key(int unsigned ch, int unsigned limit);
    for (int p = int'(limit) - 1; p >= 0; p--) begin
      if (ring_type[ch][slot_at(ch, p)] == TypeKey) return p;
    end
    return -1;
  endfunction

  // Computes the result of one word and advances the shadow state.
  function automatic frame_result_t predict_frame(op_e op, int unsigned ch,
      logic [LenW-1:0] len, logic [TypeW-1:0] typ, logic [TimeW-1:0] ts,
      logic [QSeqW-1:0] q);
    frame_result_t r;
    logic [QSeqW-1:0] off;
    logic [TotalW:0] sum;
    int unsigned s;
    int p;
    r = '0;
    r.st = StMiss;
    if (op == OpAdd) begin
      if (typ > TypeMax) begin
        r.st = StBadType;
        return r;
      end
      if (!ch_started[ch]) begin
        if (typ != TypeKey) begin
          r.st = StDropped;
          return r;
        end
        ch_started[ch] = 1'b1;
      end
      while (ch_count[ch] > 0 && ch_total[ch] >= budget_q) drop_oldest(ch);
      if (ch_count[ch] >= RingDepth) drop_oldest(ch);
      s = slot_at(ch, ch_count[ch]);
      ring_len[ch][s] = len;
      ring_type[ch][s] = typ;
      ring_time[ch][s] = ts;
      r.st = StOk;
      r.seq = ch_next_seq[ch];
      ch_next_seq[ch] = ch_next_seq[ch] + 1'b1;
      ch_count[ch]++;
      sum = ch_total[ch] + len;
      ch_total[ch] = sum[TotalW] ? '1 : sum[TotalW-1:0];
      return r;
    end
    if (!ch_started[ch]) return r;
    off = q - ch_oldest_seq[ch];
    if (op == OpGet) begin
      if (off < ch_count[ch]) begin
        s = slot_at(ch, off);
        r.st = StOk;
        r.seq = q;
        r.len = ring_len[ch][s];
        r.typ = ring_type[ch][s];
        r.tm = ring_time[ch][s];
      end
      return r;
    end
    if (op == OpPrevKey) begin
      if (off >= ch_count[ch]) return r;
      p = newest_key(ch, off);
    end else begin
      p = newest_key(ch, ch_count[ch]);
    end
    if (p >= 0) begin
      r.st = StOk;
      r.seq = ch_oldest_seq[ch] + QSeqW'(p);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (err_count < ShownErrs)
      $display("mismatch %s: got %0h, expected %0h at cycle %0d", what, got, want,
               cycle_count);
    err_count++;
  endtask

  // Sends one word, with a random gap ahead of it, and records its result.
  task automatic send_frame(op_e op, int unsigned ch, logic [LenW-1:0] len,
      logic [TypeW-1:0] typ, logic [TimeW-1:0] ts, logic [QSeqW-1:0] q);
    bit gap;
    gap = ($urandom_range(99) < send_idle_pct);
    if (gap) begin
      in_valid_i <= 1'b0;
      while (gap) begin
        @(posedge clk_i);
        gap = ($urandom_range(99) < send_idle_pct);
      end
    end
    pending_results.push_back(predict_frame(op, ch, len, typ, ts, q));
    op_i <= op;
    channel_i <= ch[0];
    frame_len_i <= len;
    frame_type_i <= typ;
    timestamp_i <= ts;
    seq_query_i <= q;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Lowers valid and waits until every result is back and the block is quiet.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_budget(logic [TotalW-1:0] value);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {1'b0, RegBudget} << 2;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    budget_q = value;
  endtask

  // Random word shaped so that queries mostly hit held descriptors.
  task automatic send_random_frame(bit long_frames);
    op_e op;
    int unsigned ch, pick;
    logic [LenW-1:0] len;
    logic [TypeW-1:0] typ;
    logic [QSeqW-1:0] q;
    pick = $urandom_range(99);
    op = (pick < 45) ? OpAdd : (pick < 75) ? OpGet : (pick < 90) ? OpPrevKey : OpLastKey;
    ch = $urandom_range(1);
    pick = $urandom_range(99);
    typ = (pick < 20) ? TypeKey : (pick < 25) ? 2'd3 : (pick < 62) ? 2'd0 : 2'd2;
    len = (long_frames || $urandom_range(9) == 0) ? LenW'($urandom) :
          LenW'($urandom_range(4095));
    pick = $urandom_range(99);
    if (pick < 80)
      q = ch_oldest_seq[ch] + QSeqW'($urandom_range(ch_count[ch] + 1));
    else if (pick < 88)
      q = ch_oldest_seq[ch] - 1'b1;
    else
      q = {16'($urandom), 32'($urandom)};
    send_frame(op, ch, len, typ, {$urandom, $urandom}, q);
  endtask

  task automatic test_directed();
    send_frame(OpGet, 0, '0, '0, '0, '0);
    send_frame(OpPrevKey, 0, '0, '0, '0, '0);
    send_frame(OpLastKey, 1, '0, '0, '0, '0);
    send_frame(OpAdd, 0, 24'd5, 2'd0, 64'd1, '0);
    send_frame(OpAdd, 0, 24'd5, 2'd2, 64'd1, '0);
    send_frame(OpAdd, 0, 24'd5, 2'd3, 64'd1, '0);
    send_frame(OpAdd, 0, '1, TypeKey, '1, '1);
    send_frame(OpAdd, 0, 24'd100, 2'd2, 64'h8000_0000_0000_0001, '0);
    send_frame(OpAdd, 0, 24'd0, 2'd0, '0, '0);
    send_frame(OpAdd, 0, 24'd7, TypeKey, 64'h1234_5678_9abc_def0, '0);
    send_frame(OpGet, 0, '0, '0, '0, 48'd0);
    send_frame(OpGet, 0, '0, '0, '0, 48'd1);
    send_frame(OpGet, 0, '0, '0, '0, 48'd3);
    send_frame(OpGet, 0, '0, '0, '0, 48'd4);
    send_frame(OpGet, 0, '0, '0, '0, '1);
    send_frame(OpPrevKey, 0, '0, '0, '0, 48'd3);
    send_frame(OpPrevKey, 0, '0, '0, '0, 48'd2);
    send_frame(OpPrevKey, 0, '0, '0, '0, 48'd0);
    send_frame(OpPrevKey, 0, '0, '0, '0, 48'd9);
    send_frame(OpLastKey, 0, '0, '0, '0, '0);
    send_frame(OpAdd, 1, '0, TypeKey, '0, '0);
    send_frame(OpGet, 1, '0, '0, '0, '0);
    send_frame(OpLastKey, 1, '0, '0, '0, '0);
    send_frame(OpPrevKey, 1, '0, '0, '0, '0);
  endtask

  // Budget extremes: a budget of one evicts before nearly every add.
  task automatic test_budget_extremes();
    write_budget(TotalW'(1));
    repeat (30) send_random_frame(1'b0);
    write_budget(TotalW'(16777216));
    repeat (40) send_random_frame(1'b1);
  endtask

  task automatic test_random_phase(int unsigned send_pct, int unsigned recv_pct,
      logic [TotalW-1:0] budget, int unsigned words);
    write_budget(budget);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (words) send_random_frame(1'b0);
  endtask

  // The receiver holds off while the sender offers words, then the sender drains.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 400;
    repeat (20) send_random_frame(1'b0);
    wait_drained();
  endtask

  // Receiver stall, with a long hold counted here once one is requested.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (hold_count < hold_cycles) begin
      out_stall_i <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Compares each result word with the oldest expectation.
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, status", status_o, '0);
      end else begin
        want = pending_results.pop_front();
        if (status_o != want.st) report_mismatch("status", status_o, want.st);
        if (seq_out_o != want.seq) report_mismatch("seq_out", seq_out_o, want.seq);
        if (len_out_o != want.len) report_mismatch("len_out", len_out_o, want.len);
        if (type_out_o != want.typ) report_mismatch("type_out", type_out_o, want.typ);
        if (time_out_o != want.tm) report_mismatch("time_out", time_out_o, want.tm);
      end
    end
  end

  initial begin
    budget_q = BudgetReset;
    for (int c = 0; c < 2; c++) begin
      ch_started[c] = 1'b0;
      ch_next_seq[c] = '0;
      ch_oldest_seq[c] = '0;
      ch_total[c] = '0;
      ch_count[c] = 0;
      ch_oldest_slot[c] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_budget_extremes();
    test_random_phase(0, 0, BudgetReset, 420);
    test_random_phase(61, 0, TotalW'(20000), 420);
    test_random_phase(0, 61, TotalW'($urandom_range(16777216, 1)), 420);
    test_random_phase(9, 9, TotalW'(300000), 420);
    test_backpressure();
    write_budget(BudgetReset);

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
